>>> sv/acfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acfp_pkg;

	localparam int unsigned ID_DIGITS_DEFAULT      = 3;
	localparam int unsigned MAX_DATA_BYTES_DEFAULT = 8;

	localparam int unsigned ID_W      = 12;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned CNT_W     = 5;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_T_LO = 8'h74;
	localparam logic [7:0] CH_T_UP = 8'h54;
	localparam logic [7:0] CH_R_LO = 8'h72;
	localparam logic [7:0] CH_R_UP = 8'h52;

	typedef enum logic [4:0] {
		PH_WAIT = 5'b00001,
		PH_ID   = 5'b00010,
		PH_LEN  = 5'b00100,
		PH_DATA = 5'b01000,
		PH_TERM = 5'b10000
	} acfp_phase_t;

	typedef struct packed {
		logic [ID_W-1:0]      frame_id;
		logic                 remote;
		logic [LEN_W-1:0]     length;
		logic [PAYLOAD_W-1:0] payload;
		logic                 malformed;
	} acfp_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} acfp_nibble_t;

	// Decodes one ASCII hex digit; ok is low for any other character.
	function automatic acfp_nibble_t hex_decode(input logic [7:0] c);
		acfp_nibble_t n;
		n.ok    = 1'b1;
		n.value = 4'h0;
		if (c inside {[8'h30:8'h39]}) begin
			n.value = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			n.value = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			n.value = 4'(c - 8'h37);
		end else begin
			n.ok = 1'b0;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

>>> sv/acfp_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module acfp_parse import acfp_pkg::*; #(
	parameter int unsigned ID_DIGITS      = ID_DIGITS_DEFAULT,
	parameter int unsigned MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [7:0]   rx_byte,
	output acfp_result_t      result,
	output logic              emit
);

	acfp_phase_t          phase_q, phase_nxt;
	logic [CNT_W-1:0]     cnt_q, cnt_nxt, cnt_inc;
	logic [ID_W-1:0]      id_q, id_nxt;
	logic                 remote_q, remote_nxt;
	logic [LEN_W-1:0]     len_q, len_nxt;
	logic [PAYLOAD_W-1:0] payload_q, payload_nxt;
	acfp_nibble_t         nib;
	logic [5:0]           shift;
	logic                 err;

	assign nib     = hex_decode(rx_byte);
	assign cnt_inc = cnt_q + CNT_W'(1);
	// High nibble of a byte comes first, so an even digit lands at bit 4 of its byte.
	assign shift   = {cnt_q[3:1], ~cnt_q[0], 2'b00};

	always_comb begin
		phase_nxt   = phase_q;
		cnt_nxt     = cnt_q;
		id_nxt      = id_q;
		remote_nxt  = remote_q;
		len_nxt     = len_q;
		payload_nxt = payload_q;
		err         = 1'b0;
		emit        = 1'b0;
		result      = '0;
		case (phase_q)
			PH_WAIT: begin
				if (rx_byte inside {CH_T_LO, CH_T_UP, CH_R_LO, CH_R_UP}) begin
					remote_nxt  = (rx_byte == CH_R_LO) || (rx_byte == CH_R_UP);
					id_nxt      = '0;
					len_nxt     = '0;
					payload_nxt = '0;
					cnt_nxt     = '0;
					phase_nxt   = PH_ID;
				end
			end
			PH_ID: begin
				if (!nib.ok) begin
					err = 1'b1;
				end else begin
					id_nxt = {id_q[ID_W-5:0], nib.value};
					if (cnt_inc >= CNT_W'(ID_DIGITS)) begin
						cnt_nxt   = '0;
						phase_nxt = PH_LEN;
					end else begin
						cnt_nxt = cnt_inc;
					end
				end
			end
			PH_LEN: begin
				if (!nib.ok || (nib.value > LEN_W'(MAX_DATA_BYTES))) begin
					err = 1'b1;
				end else begin
					len_nxt   = nib.value;
					cnt_nxt   = '0;
					phase_nxt = (nib.value == '0) ? PH_TERM : PH_DATA;
				end
			end
			PH_DATA: begin
				if (!nib.ok) begin
					err = 1'b1;
				end else begin
					payload_nxt = payload_q | (PAYLOAD_W'(nib.value) << shift);
					if (cnt_inc >= {len_q, 1'b0}) begin
						cnt_nxt   = '0;
						phase_nxt = PH_TERM;
					end else begin
						cnt_nxt = cnt_inc;
					end
				end
			end
			PH_TERM: begin
				if (rx_byte != CH_CR) begin
					err = 1'b1;
				end else begin
					emit             = 1'b1;
					result.frame_id  = id_q;
					result.remote    = remote_q;
					result.length    = len_q;
					result.payload   = payload_q;
					phase_nxt        = PH_WAIT;
					cnt_nxt          = '0;
				end
			end
			default: begin
				phase_nxt = PH_WAIT;
				cnt_nxt   = '0;
			end
		endcase
		if (err) begin
			emit             = 1'b1;
			result           = '0;
			result.malformed = 1'b1;
			phase_nxt        = PH_WAIT;
			cnt_nxt          = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			cnt_q     <= '0;
			id_q      <= '0;
			remote_q  <= 1'b0;
			len_q     <= '0;
			payload_q <= '0;
		end else if (fire) begin
			phase_q   <= phase_nxt;
			cnt_q     <= cnt_nxt;
			id_q      <= id_nxt;
			remote_q  <= remote_nxt;
			len_q     <= len_nxt;
			payload_q <= payload_nxt;
		end
	end

endmodule

`default_nettype wire

>>> sv/acfp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module acfp_out_reg import acfp_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire acfp_result_t  result,
	input  wire logic          out_ready,
	output logic               out_valid,
	output logic               free,
	output acfp_result_t       held
);

	logic         valid_q;
	acfp_result_t data_q;

	// The register can take a new beat when empty or when its beat leaves this cycle.
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign held      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

`default_nettype wire

>>> sv/ascii_can_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes a serial-line CAN adapter stream, one ASCII byte per beat: a start letter
// (t, T, r or R), ID_DIGITS hex identifier digits, one length digit, two hex digits per
// data byte and a carriage return. A byte may be offered every cycle; the frame result, or a
// malformed result on a bad character or a length digit above MAX_DATA_BYTES, shows on the
// output in the cycle after the byte that completes it. The input is stalled only while the
// single output register holds a result that the consumer has not taken.

module ascii_can_frame_parser import acfp_pkg::*; #(
	parameter int unsigned ID_DIGITS      = ID_DIGITS_DEFAULT,
	parameter int unsigned MAX_DATA_BYTES = MAX_DATA_BYTES_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [ID_W-1:0]           frame_id,
	output logic                      remote,
	output logic [LEN_W-1:0]          length,
	output logic [PAYLOAD_W-1:0]      payload,
	output logic                      malformed
);

	logic         fire;
	logic         emit;
	logic         free;
	acfp_result_t result;
	acfp_result_t held;

	assign in_ready = free;
	assign fire     = in_valid && in_ready;

	acfp_parse #(
		.ID_DIGITS      (ID_DIGITS),
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.rx_byte (rx_byte),
		.result  (result),
		.emit    (emit)
	);

	acfp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && emit),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (free),
		.held      (held)
	);

	assign frame_id  = held.frame_id;
	assign remote    = held.remote;
	assign length    = held.length;
	assign payload   = held.payload;
	assign malformed = held.malformed;

	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && malformed |-> frame_id == '0 && !remote && length == '0 && payload == '0)
		else $error("malformed result carries nonzero fields");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !malformed |-> length <= LEN_W'(MAX_DATA_BYTES))
		else $error("frame length above limit");

	a_payload_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !malformed && length < LEN_W'(8) |->
			(payload >> {length, 3'b000}) == '0)
		else $error("payload bytes beyond length are nonzero");

	a_result_follows_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire))
		else $error("result appeared without an accepted byte");

endmodule

`default_nettype wire
